/* design/retransmit_timeout_queue_top_assert.svh */
// ----------------------------------------------------------------------------
// retransmit timeout queue assertion macros
// implication checks sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef RETRANSMIT_TIMEOUT_QUEUE_TOP_ASSERT_SVH
`define RETRANSMIT_TIMEOUT_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define RTQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rtq assertion failed");

// next-cycle implication
`define RTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rtq assertion failed");

`endif

/* design/rtq_pkg.sv */
// ----------------------------------------------------------------------------
// rtq_pkg
// types and codes shared by the retransmit timeout queue
// ----------------------------------------------------------------------------
package rtq_pkg;

  typedef enum logic [1:0] {
    MODE_SEND  = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_CLOSE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_RETX  = 3'd0,
    KIND_DROP  = 3'd1,
    KIND_EVICT = 3'd2,
    KIND_ACK   = 3'd3,
    KIND_CLOSE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_MV,
    ST_FIN
  } state_e;

  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY   = 8'd1;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] stamp;
    logic [7:0]  retries;
    logic [15:0] target;
    logic [15:0] handle;
    logic [15:0] length;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] seq;
    logic [15:0] target;
    logic [15:0] handle;
    logic [15:0] length;
    logic [7:0]  attempt;
  } report_t;

  typedef struct packed {
    report_t rep;
    logic    last;
  } out_word_t;

  typedef struct packed {
    logic pend;
    logic room;
  } buf_stat_t;

endpackage

/* design/retransmit_timeout_queue_top.sv */
// send into a non-full table writes the entry directly; ack, tick and a full send
// scan the table through the entry ram port, reading and then evaluating each entry
// close scans the same way, a moved-in entry is checked without a new read
// results leave through a one-word output register after a one-word hold stage
// reset clears count, tick time, pointers and handshake state; ram is not cleared
// ----------------------------------------------------------------------------
// retransmit_timeout_queue_top
// ordered table of unacknowledged packets with timeout and retry handling
// ----------------------------------------------------------------------------
module retransmit_timeout_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rtq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rtq_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic [31:0]                  seq_num_i,
  input  logic [15:0]                  target_i,
  input  logic [15:0]                  buffer_handle_i,
  input  logic [15:0]                  packet_length_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   kind_o,
  output logic [31:0]                  seq_out_o,
  output logic [15:0]                  target_out_o,
  output logic [15:0]                  handle_out_o,
  output logic [15:0]                  length_out_o,
  output logic [7:0]                   attempt_o,
  output logic                         last_o
);
  import rtq_pkg::*;

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] One  = CntW'(1);

  state_e state_q, state_d;
  mode_e  mode_q;
  logic [31:0] seq_q, tick_q, tick_d;
  logic [15:0] tgt_q, hnd_q, len_q, tmo_q;
  logic [7:0]  lim_q;
  logic [CntW-1:0] rd_q, rd_d, wr_q, wr_d, cnt_q, cnt_d;

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_q, wdata;
  logic   mem_we, mem_re;
  logic [IdxW-1:0] waddr, raddr;

  buf_stat_t stat;
  report_t   rep;
  out_word_t oword;
  logic      push, flush, in_acc;
  logic      hit, keep, stall, scan_end, at_last;
  logic [31:0] age;
  logic        timed, at_lim;
  entry_t      upd;

  assign in_ready_o  = (state_q == ST_IDLE) && !stat.pend;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign age      = tick_q - rdata_q.stamp;
  assign timed    = age > {16'd0, tmo_q};
  assign at_lim   = rdata_q.retries >= lim_q;
  assign scan_end = rd_q == cnt_q;
  assign at_last  = rd_q == (cnt_q - One);

  // evaluation of the entry at the read port
  always_comb begin
    hit  = 1'b0;
    keep = 1'b1;
    upd  = rdata_q;
    rep  = '{kind: KIND_ACK, seq: rdata_q.seq, target: rdata_q.target,
             handle: rdata_q.handle, length: rdata_q.length,
             attempt: rdata_q.retries};
    unique case (mode_q)
      MODE_SEND: begin
        hit      = rd_q == '0;
        keep     = !hit;
        rep.kind = KIND_EVICT;
      end
      MODE_ACK: begin
        hit  = rdata_q.seq == seq_q;
        keep = !hit;
      end
      MODE_TICK: begin
        if (timed && at_lim) begin
          hit      = 1'b1;
          keep     = 1'b0;
          rep.kind = KIND_DROP;
        end else if (timed) begin
          hit         = 1'b1;
          upd.stamp   = tick_q;
          upd.retries = rdata_q.retries + 8'd1;
          rep.kind    = KIND_RETX;
          rep.attempt = upd.retries;
        end
      end
      MODE_CLOSE: begin
        hit      = rdata_q.target == tgt_q;
        keep     = !hit;
        rep.kind = KIND_CLOSE;
      end
      default: ;
    endcase
  end

  assign stall = hit && !stat.room;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) begin
        state_d = (mode_e'(mode_i) == MODE_SEND && cnt_q != Full) ? ST_FIN : ST_RD;
      end
      ST_RD: state_d = scan_end ? ST_FIN : ST_EV;
      ST_EV: if (!stall) begin
        if (mode_q == MODE_CLOSE && hit) state_d = at_last ? ST_FIN : ST_MV;
        else state_d = ST_RD;
      end
      ST_MV:  state_d = ST_EV;
      ST_FIN: if (!stat.pend) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = wr_q[IdxW-1:0];
    raddr  = rd_q[IdxW-1:0];
    wdata  = upd;
    push   = 1'b0;
    flush  = 1'b0;
    rd_d   = rd_q;
    wr_d   = wr_q;
    cnt_d  = cnt_q;
    tick_d = tick_q;
    unique case (state_q)
      ST_IDLE: begin
        rd_d = '0;
        wr_d = '0;
        if (in_acc) begin
          if (mode_e'(mode_i) == MODE_TICK) tick_d = tick_q + 32'd1;
          if (mode_e'(mode_i) == MODE_SEND && cnt_q != Full) begin
            mem_we = 1'b1;
            waddr  = cnt_q[IdxW-1:0];
            wdata  = '{seq: seq_num_i, stamp: tick_q, retries: 8'd0,
                       target: target_i, handle: buffer_handle_i,
                       length: packet_length_i};
            cnt_d  = cnt_q + One;
          end
        end
      end
      ST_RD: begin
        if (scan_end) begin
          if (mode_q != MODE_CLOSE) cnt_d = wr_q;
          if (mode_q == MODE_SEND) begin
            mem_we = 1'b1;
            wdata  = '{seq: seq_q, stamp: tick_q, retries: 8'd0,
                       target: tgt_q, handle: hnd_q, length: len_q};
            cnt_d  = wr_q + One;
          end
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_EV: if (!stall) begin
        push = hit;
        if (mode_q == MODE_CLOSE) begin
          if (!hit) begin
            rd_d = rd_q + One;
          end else if (at_last) begin
            cnt_d = cnt_q - One;
          end else begin
            mem_re = 1'b1;
            raddr  = cnt_q[IdxW-1:0] - IdxW'(1);
          end
        end else begin
          rd_d = rd_q + One;
          if (keep) begin
            mem_we = 1'b1;
            wr_d   = wr_q + One;
          end
        end
      end
      ST_MV: begin
        mem_we = 1'b1;
        waddr  = rd_q[IdxW-1:0];
        wdata  = rdata_q;
        cnt_d  = cnt_q - One;
      end
      ST_FIN: flush = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      tick_q  <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      tmo_q   <= 16'd3;
      lim_q   <= 8'd3;
      mode_q  <= MODE_SEND;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tick_q  <= tick_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      if (in_acc) mode_q <= mode_e'(mode_i);
      if (cfg_valid_i && cfg_index_i == CFG_TIMEOUT) tmo_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_RETRY) lim_q <= cfg_data_i[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seq_q <= seq_num_i;
      tgt_q <= target_i;
      hnd_q <= buffer_handle_i;
      len_q <= packet_length_i;
    end
  end

  rtq_report_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rep_i       (rep),
    .flush_i     (flush),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (oword),
    .stat_o      (stat)
  );

  assign kind_o       = oword.rep.kind;
  assign seq_out_o    = oword.rep.seq;
  assign target_out_o = oword.rep.target;
  assign handle_out_o = oword.rep.handle;
  assign length_out_o = oword.rep.length;
  assign attempt_o    = oword.rep.attempt;
  assign last_o       = oword.last;

endmodule

/* design/rtq_report_buf.sv */
// ----------------------------------------------------------------------------
// rtq_report_buf
// holds one pending report back so the final word can carry the last flag
// ----------------------------------------------------------------------------
module rtq_report_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rtq_pkg::report_t   rep_i,
  input  logic               flush_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output rtq_pkg::out_word_t out_o,
  output rtq_pkg::buf_stat_t stat_o
);
  import rtq_pkg::*;

  logic      pend_valid_q, pend_valid_d;
  report_t   pend_q, pend_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;
  logic      can_out;

  assign can_out = !out_valid_q || out_ready_i;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    if (push_i) begin
      if (pend_valid_q) begin
        out_d       = '{rep: pend_q, last: 1'b0};
        out_valid_d = 1'b1;
      end
      pend_d       = rep_i;
      pend_valid_d = 1'b1;
    end else if (flush_i && pend_valid_q && can_out) begin
      out_d        = '{rep: pend_q, last: 1'b1};
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign stat_o.pend = pend_valid_q;
  assign stat_o.room = !pend_valid_q || can_out;

endmodule

/* design/rtq_checker.sv */
// ----------------------------------------------------------------------------
// rtq_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "retransmit_timeout_queue_top_assert.svh"

module rtq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  kind_o,
  input logic [31:0] seq_out_o,
  input logic [7:0]  attempt_o,
  input logic        last_o
);
  import rtq_pkg::*;

  `RTQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `RTQ_ASSERT_NEXT(a_seq_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(seq_out_o))
  `RTQ_ASSERT_IMPLY(a_evict_last, clk_i, rst_ni, out_valid_o && kind_o == KIND_EVICT, last_o)
  `RTQ_ASSERT_IMPLY(a_retx_count, clk_i, rst_ni, out_valid_o && kind_o == KIND_RETX, attempt_o != 8'd0)

endmodule

bind retransmit_timeout_queue_top rtq_checker u_rtq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .seq_out_o   (seq_out_o),
  .attempt_o   (attempt_o),
  .last_o      (last_o)
);

/* tb/tb_retransmit_timeout_queue_top.sv */
// ----------------------------------------------------------------------------
// tb_retransmit_timeout_queue_top
// self-checking bench: random bursty sends, acks, ticks and closes go through
// a queue-driven driver, an in-bench table model predicts every report and a
// monitor compares each output word field by field across several settings
// ----------------------------------------------------------------------------
module tb_retransmit_timeout_queue_top;
  import rtq_pkg::*;

  localparam int Depth = 16;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 200;

  typedef struct {
    mode_e       mode;
    logic [31:0] seq;
    logic [15:0] target;
    logic [15:0] handle;
    logic [15:0] length;
  } cmd_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] seq;
    logic [15:0] target;
    logic [15:0] handle;
    logic [15:0] length;
    logic [7:0]  attempt;
    logic        last;
  } report_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic [31:0] seq_num_i = '0;
  logic [15:0] target_i = '0;
  logic [15:0] buffer_handle_i = '0;
  logic [15:0] packet_length_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] kind_o;
  logic [31:0] seq_out_o;
  logic [15:0] target_out_o;
  logic [15:0] handle_out_o;
  logic [15:0] length_out_o;
  logic [7:0] attempt_o;
  logic last_o;

  retransmit_timeout_queue_top #(.QUEUE_DEPTH(Depth)) u_top (.*);

  always #5 clk_i = ~clk_i;

  // table model
  logic [31:0] tbl_seq [Depth];
  logic [31:0] tbl_stamp [Depth];
  logic [7:0]  tbl_retries [Depth];
  logic [15:0] tbl_target [Depth];
  logic [15:0] tbl_handle [Depth];
  logic [15:0] tbl_length [Depth];
  int          tbl_count = 0;
  logic [31:0] tick_now = '0;
  logic [15:0] timeout_reg = 16'd3;
  logic [7:0]  retry_reg = 8'd3;

  cmd_t         cmd_queue [$];
  report_word_t report_queue [$];
  int           errors = 0;
  int           cycles = 0;
  logic [31:0]  seq_pool [8];
  logic [15:0]  tgt_pool [4];

  function automatic report_word_t entry_report(logic [2:0] kind, int i);
    report_word_t r;
    r.kind = kind;
    r.seq = tbl_seq[i];
    r.target = tbl_target[i];
    r.handle = tbl_handle[i];
    r.length = tbl_length[i];
    r.attempt = tbl_retries[i];
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void move_slot(int dst, int src);
    tbl_seq[dst] = tbl_seq[src];
    tbl_stamp[dst] = tbl_stamp[src];
    tbl_retries[dst] = tbl_retries[src];
    tbl_target[dst] = tbl_target[src];
    tbl_handle[dst] = tbl_handle[src];
    tbl_length[dst] = tbl_length[src];
  endfunction

  function automatic void remove_ordered(int i);
    for (int j = i; j + 1 < tbl_count; j++) move_slot(j, j + 1);
    tbl_count--;
  endfunction

  function automatic void predict_reports(cmd_t c);
    report_word_t got [$];
    int i;
    logic [31:0] age;
    i = 0;
    case (c.mode)
      MODE_SEND: begin
        if (tbl_count >= Depth) begin
          got.push_back(entry_report(KIND_EVICT, 0));
          remove_ordered(0);
        end
        tbl_seq[tbl_count] = c.seq;
        tbl_stamp[tbl_count] = tick_now;
        tbl_retries[tbl_count] = '0;
        tbl_target[tbl_count] = c.target;
        tbl_handle[tbl_count] = c.handle;
        tbl_length[tbl_count] = c.length;
        tbl_count++;
      end
      MODE_ACK: begin
        while (i < tbl_count) begin
          if (tbl_seq[i] == c.seq) begin
            got.push_back(entry_report(KIND_ACK, i));
            remove_ordered(i);
          end else i++;
        end
      end
      MODE_TICK: begin
        tick_now = tick_now + 1;
        while (i < tbl_count) begin
          age = tick_now - tbl_stamp[i];
          if (age > {16'd0, timeout_reg}) begin
            if (tbl_retries[i] >= retry_reg) begin
              got.push_back(entry_report(KIND_DROP, i));
              remove_ordered(i);
              continue;
            end
            tbl_stamp[i] = tick_now;
            tbl_retries[i] = tbl_retries[i] + 8'd1;
            got.push_back(entry_report(KIND_RETX, i));
          end
          i++;
        end
      end
      default: begin
        while (i < tbl_count) begin
          if (tbl_target[i] == c.target) begin
            got.push_back(entry_report(KIND_CLOSE, i));
            move_slot(i, tbl_count - 1);
            tbl_count--;
          end else i++;
        end
      end
    endcase
    if (got.size() > 0) got[got.size() - 1].last = 1'b1;
    foreach (got[k]) report_queue.push_back(got[k]);
  endfunction

  // driver
  int acc_count = 0;
  int acc_seen = 0;
  int burst_left = 4;
  int gap_left = 0;
  logic [15:0] stall_pattern = 16'hffff;
  int pat_pos = 0;

  always @(negedge clk_i) begin
    cmd_t c;
    logic taken;
    taken = (acc_count != acc_seen);
    acc_seen = acc_count;
    if (rst_ni && (!in_valid_i || taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        in_valid_i <= 1'b1;
        mode_i <= c.mode;
        seq_num_i <= c.seq;
        target_i <= c.target;
        buffer_handle_i <= c.handle;
        packet_length_i <= c.length;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else in_valid_i <= 1'b0;
    end
    out_ready_i <= rst_ni && stall_pattern[pat_pos];
    pat_pos = (pat_pos + 1) % 16;
    if (pat_pos == 0 && $urandom_range(0, 3) == 0)
      stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
  end

  // monitor
  always @(posedge clk_i) begin
    cmd_t c;
    report_word_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("retransmit_timeout_queue_top: mismatch");
      $finish;
    end else begin
      if (in_valid_i && in_ready_o) begin
        c.mode = mode_e'(mode_i);
        c.seq = seq_num_i;
        c.target = target_i;
        c.handle = buffer_handle_i;
        c.length = packet_length_i;
        predict_reports(c);
        acc_count++;
      end
      if (out_valid_o && out_ready_i) begin
        if (report_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word kind %0d seq %h", kind_o, seq_out_o);
        end else begin
          e = report_queue.pop_front();
          if (kind_o !== e.kind || seq_out_o !== e.seq || target_out_o !== e.target ||
              handle_out_o !== e.handle || length_out_o !== e.length ||
              attempt_o !== e.attempt || last_o !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("exp k%0d %h %h %h %h a%0d l%0d got k%0d %h %h %h %h a%0d l%0d",
                       e.kind, e.seq, e.target, e.handle, e.length, e.attempt, e.last,
                       kind_o, seq_out_o, target_out_o, handle_out_o, length_out_o,
                       attempt_o, last_o);
          end
        end
      end
    end
  end

  function automatic cmd_t make_cmd(mode_e m, logic [31:0] s, logic [15:0] t);
    cmd_t c;
    c.mode = m;
    c.seq = s;
    c.target = t;
    c.handle = 16'($urandom);
    c.length = 16'($urandom);
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    int r;
    logic [31:0] s;
    logic [15:0] t;
    r = $urandom_range(0, 99);
    s = ($urandom_range(0, 9) == 0) ? $urandom : seq_pool[$urandom_range(0, 7)];
    t = ($urandom_range(0, 9) == 0) ? 16'($urandom) : tgt_pool[$urandom_range(0, 3)];
    if (r < 45) return make_cmd(MODE_SEND, s, t);
    if (r < 63) return make_cmd(MODE_ACK, s, t);
    if (r < 90) return make_cmd(MODE_TICK, s, t);
    return make_cmd(MODE_CLOSE, s, t);
  endfunction

  task automatic wait_idle();
    while (cmd_queue.size() > 0 || in_valid_i || report_queue.size() > 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_TIMEOUT) timeout_reg = data;
    else retry_reg = data[7:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [15:0] tmo, logic [7:0] rty, int n);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_RETRY, {8'd0, rty});
    foreach (seq_pool[k]) seq_pool[k] = $urandom;
    foreach (tgt_pool[k]) tgt_pool[k] = 16'($urandom);
    for (int k = 0; k < n; k++) cmd_queue.push_back(random_cmd());
    wait_idle();
  endtask

  initial begin
    cmd_t c;
    foreach (seq_pool[k]) seq_pool[k] = $urandom;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: field extremes, fill past full, ack hit and miss, timeouts, close
    c = make_cmd(MODE_SEND, 32'hffff_ffff, 16'hffff);
    c.handle = 16'hffff;
    c.length = 16'hffff;
    cmd_queue.push_back(c);
    c = make_cmd(MODE_SEND, 32'd0, 16'd0);
    c.handle = 16'd0;
    c.length = 16'd0;
    cmd_queue.push_back(c);
    for (int k = 0; k < 15; k++)
      cmd_queue.push_back(make_cmd(MODE_SEND, seq_pool[k % 4], 16'(k % 3)));
    cmd_queue.push_back(make_cmd(MODE_ACK, seq_pool[1], 16'd0));
    cmd_queue.push_back(make_cmd(MODE_ACK, 32'h1234_5678, 16'd0));
    for (int k = 0; k < 5; k++) cmd_queue.push_back(make_cmd(MODE_TICK, 32'd0, 16'd0));
    cmd_queue.push_back(make_cmd(MODE_CLOSE, 32'd0, 16'd1));
    cmd_queue.push_back(make_cmd(MODE_CLOSE, 32'd0, 16'h7777));
    wait_idle();
    run_phase(16'd0, 8'd0, 60);
    run_phase(16'hffff, 8'hff, 50);
    run_phase(16'd2, 8'd1, 90);
    run_phase(16'd1, 8'hff, 40);
    run_phase(16'd4, 8'd3, 100);
    if (errors == 0 && report_queue.size() == 0) begin
      $display("retransmit_timeout_queue_top: match");
    end else begin
      $display("retransmit_timeout_queue_top: mismatch");
    end
    $finish;
  end

endmodule
